// ----- hw/rtl/ida_pkg.sv -----
// Shared types, constants and controller codes for the decimal text converter.
`default_nettype none

package ida_pkg;

   localparam int NumBits   = 64;
   localparam int NumDigits = 20;
   localparam int BcdWidth  = NumDigits * 4;
   localparam int CntWidth  = $clog2(NumBits);
   localparam int LenWidth  = 5;

   localparam logic [5:0] CharZero  = 6'd48;
   localparam logic [5:0] CharMinus = 6'd45;
   localparam logic [5:0] CharNine  = 6'd57;

   typedef struct packed {
      logic [NumBits-1:0] number_bits;
      logic               is_signed;
   } req_type;

   typedef struct packed {
      logic [5:0]          char_code;
      logic [LenWidth-1:0] text_length;
      logic                last_char;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic trim;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic trim_needed;
      logic out_free;
      logic sign_pending;
      logic digit_last;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ida_ctrl.sv -----
// Controller state machine that sequences load, conversion, trimming and emission.
`default_nettype none

module ida_ctrl
   import ida_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.conv_done) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (!status.trim_needed) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && !status.sign_pending && status.digit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
         end
         ST_TRIM: begin
            cmd.trim = status.trim_needed;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ida_datapath.sv -----
// Datapath with the binary to BCD shift register, digit trimming and output word register.
`default_nettype none

module ida_datapath
   import ida_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [NumBits-1:0]  mag_ff, mag_in;
   logic [BcdWidth-1:0] bcd_ff, bcd_in;
   logic [BcdWidth-1:0] adj;
   logic [CntWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic [LenWidth-1:0] ndig_ff, ndig_in;
   logic [LenWidth-1:0] sent_ff, sent_in;
   logic                neg_ff, neg_in;
   logic                sign_pending_ff, sign_pending_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                neg_load;
   logic [3:0]          top_digit;
   logic [LenWidth-1:0] text_len;

   assign top_digit = bcd_ff[BcdWidth-1 -: 4];
   assign text_len  = ndig_ff + {{(LenWidth-1){1'b0}}, neg_ff};
   assign neg_load  = req_data.is_signed & req_data.number_bits[NumBits-1];

   always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
         adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                    : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      status.conv_done    = (bit_cnt_ff == CntWidth'(NumBits - 1));
      status.trim_needed  = (top_digit == 4'd0) && (ndig_ff != LenWidth'(1));
      status.out_free     = !rsp_valid_ff || !rsp_stall;
      status.sign_pending = sign_pending_ff;
      status.digit_last   = (sent_ff + LenWidth'(1) == ndig_ff);
   end

   always_comb begin
      mag_in          = mag_ff;
      bcd_in          = bcd_ff;
      bit_cnt_in      = bit_cnt_ff;
      ndig_in         = ndig_ff;
      sent_in         = sent_ff;
      neg_in          = neg_ff;
      sign_pending_in = sign_pending_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         mag_in          = neg_load ? ~req_data.number_bits + NumBits'(1)
                                    : req_data.number_bits;
         neg_in          = neg_load;
         sign_pending_in = neg_load;
         bcd_in          = '0;
         bit_cnt_in      = '0;
         ndig_in         = LenWidth'(NumDigits);
         sent_in         = '0;
      end
      if (cmd.shift) begin
         bcd_in     = {adj[BcdWidth-2:0], mag_ff[NumBits-1]};
         mag_in     = {mag_ff[NumBits-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + CntWidth'(1);
      end
      if (cmd.trim) begin
         bcd_in  = {bcd_ff[BcdWidth-5:0], 4'd0};
         ndig_in = ndig_ff - LenWidth'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.text_length = text_len;
         if (sign_pending_ff) begin
            rsp_in.char_code = CharMinus;
            rsp_in.last_char = 1'b0;
            sign_pending_in  = 1'b0;
         end else begin
            rsp_in.char_code = CharZero + {2'b00, top_digit};
            rsp_in.last_char = status.digit_last;
            bcd_in           = {bcd_ff[BcdWidth-5:0], 4'd0};
            sent_in          = sent_ff + LenWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff          <= mag_in;
      bcd_ff          <= bcd_in;
      bit_cnt_ff      <= bit_cnt_in;
      ndig_ff         <= ndig_in;
      sent_ff         <= sent_in;
      neg_ff          <= neg_in;
      sign_pending_ff <= sign_pending_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A word is only ever a minus sign or a decimal digit.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.char_code == CharMinus) ||
                       ((rsp_ff.char_code >= CharZero) && (rsp_ff.char_code <= CharNine)))
      else $error("output word holds an illegal character");

   // The minus sign is never the final word of a number.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.char_code == CharMinus)) |-> !rsp_ff.last_char)
      else $error("minus sign flagged as last word");

   // The text length stays within one to twenty characters.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.text_length >= LenWidth'(1)) &&
                       (rsp_ff.text_length <= LenWidth'(NumDigits)))
      else $error("text length out of range");

   // Trimming never removes the only remaining digit.
   a_trim_keeps_digit: assert property (@(posedge clock) disable iff (reset)
      cmd.trim |-> (ndig_ff > LenWidth'(1)))
      else $error("trim step with a single digit left");

   // Conversion finishes before any word is emitted.
   a_emit_after_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !cmd.shift && !cmd.trim && !cmd.load)
      else $error("emit overlaps another datapath command");

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_decimal_ascii.sv -----
// Top level of the 64-bit integer to decimal ASCII text converter.
// The req channel takes one word per number: a 64-bit pattern and a flag
// that marks it as two's complement signed. The rsp channel returns the
// decimal text one character per word, most significant first, with a
// leading minus sign for negative signed values. Every rsp word carries
// the total text length, and the final one has last_char set.
// After a req word is accepted, shift-and-add-3 conversion runs over
// all 64 bits of the magnitude, then up to 19 leading zero digits of
// the 20-digit BCD result are stripped, then the characters are sent,
// one per rsp word, waiting while the receiver stalls. The BCD shift
// register is the single shared unit, so one number is in work at a time.
// The next req word is taken as soon as the final character sits in the
// output register, even if the receiver stalls it.
// While rsp_stall is high the output word holds and emission waits.
// Reset empties the output register and returns the controller to idle.
`default_nettype none

module integer_to_decimal_ascii
   import ida_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   ida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ida_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the integer to decimal ASCII converter.
`default_nettype none

module tb
   import ida_pkg::*;
();

   localparam int RandomNumbers = 238;
   localparam int DrainCycles   = 120;
   localparam int CycleLimit    = 800000;
   localparam int TableRows     = 22;

   typedef struct packed {
      logic [NumBits-1:0] number;
      logic               sgn;
      logic [159:0]       text;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_chars [$];
   int      error_count = 0;
   int      numbers_sent = 0;
   int      negatives_sent = 0;
   int      chars_checked = 0;
   int      cycle_count = 0;
   int      sender_calm = 0;
   int      receiver_calm = 0;

   // An empty text field means the row is checked against the predictor.
   directed_row_type directed_table [TableRows] = '{
      '{64'd0, 1'b0, "0"},
      '{64'd0, 1'b1, "0"},
      '{64'd1, 1'b0, "1"},
      '{64'd9, 1'b1, "9"},
      '{64'd10, 1'b0, "10"},
      '{64'd99, 1'b1, "99"},
      '{64'd100, 1'b0, "100"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, "18446744073709551615"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"},
      '{64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808"},
      '{64'h8000_0000_0000_0000, 1'b0, "9223372036854775808"},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807"},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, "9223372036854775807"},
      '{64'd10000000000000000000, 1'b0, "10000000000000000000"},
      '{64'd9999999999999999999, 1'b0, "9999999999999999999"},
      '{64'hFFFF_FFFF_FFFF_FFF6, 1'b1, "-10"},
      '{64'hFFFF_FFFF_FFFF_FFF7, 1'b1, "-9"},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 160'd0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 160'd0},
      '{64'h5555_5555_5555_5555, 1'b0, 160'd0},
      '{64'h5555_5555_5555_5555, 1'b1, 160'd0},
      '{64'd1234567890, 1'b1, 160'd0}
   };

   integer_to_decimal_ascii uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic void predict_text(req_type w);
      logic                negative;
      logic [NumBits-1:0]  magnitude;
      logic [3:0]          digits [NumDigits];
      int                  count;
      logic [LenWidth-1:0] total;
      rsp_type             c;
      negative = w.is_signed && w.number_bits[NumBits-1];
      magnitude = negative ? (~w.number_bits + 64'd1) : w.number_bits;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % 64'd10);
         magnitude = magnitude / 64'd10;
         count++;
      end while (magnitude != 64'd0 && count < NumDigits);
      total = LenWidth'(count + (negative ? 1 : 0));
      if (negative) begin
         c.char_code = CharMinus;
         c.text_length = total;
         c.last_char = (total == 1);
         expected_chars.push_back(c);
      end
      for (int i = count - 1; i >= 0; i--) begin
         c.char_code = CharZero + {2'b00, digits[i]};
         c.text_length = total;
         c.last_char = (i == 0);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic void push_typed_text(logic [159:0] text);
      int         n;
      int         k;
      logic [7:0] ch;
      rsp_type    c;
      n = 0;
      k = 0;
      for (int i = 0; i < NumDigits; i++) begin
         if (text[8*i +: 8] != 8'd0) n++;
      end
      for (int i = NumDigits - 1; i >= 0; i--) begin
         ch = text[8*i +: 8];
         if (ch != 8'd0) begin
            k++;
            c.char_code = ch[5:0];
            c.text_length = LenWidth'(n);
            c.last_char = (k == n);
            expected_chars.push_back(c);
         end
      end
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2);
      return $urandom_range(0, 18);
   endfunction

   function automatic req_type random_number();
      req_type            w;
      logic [NumBits-1:0] power;
      w.is_signed = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: begin
            w.number_bits = {$urandom, $urandom};
         end
         1: begin
            w.number_bits = 64'($urandom_range(0, 999));
            if (w.is_signed && $urandom_range(0, 1)) w.number_bits = -w.number_bits;
         end
         2: begin
            w.number_bits = {$urandom, $urandom} >> $urandom_range(0, 63);
         end
         3: begin
            power = 64'd1;
            repeat ($urandom_range(0, 19)) power = power * 64'd10;
            w.number_bits = power + 64'($urandom_range(0, 2)) - 64'd1;
            if (w.is_signed && $urandom_range(0, 1)) w.number_bits = -w.number_bits;
         end
         4: begin
            if ($urandom_range(0, 1)) begin
               w.number_bits = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 20))
                               - 64'd10;
            end else begin
               w.number_bits = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
            end
         end
         default: begin
            w.number_bits = {$urandom, $urandom};
         end
      endcase
      return w;
   endfunction

   task automatic send_number(req_type w, logic [159:0] text);
      int gap;
      gap = draw_wait(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (text != 160'd0) push_typed_text(text);
      else predict_text(w);
      numbers_sent++;
      if (w.is_signed && w.number_bits[NumBits-1]) negatives_sent++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d characters outstanding.",
                  cycle_count, expected_chars.size());
         $display("** integer_to_decimal_ascii: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, actual %p", $time, rsp_data);
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.char_code !== want.char_code) begin
               error_count++;
               $display("%0t: char_code expected %0d actual %0d",
                        $time, want.char_code, rsp_data.char_code);
            end
            if (rsp_data.text_length !== want.text_length) begin
               error_count++;
               $display("%0t: text_length expected %0d actual %0d",
                        $time, want.text_length, rsp_data.text_length);
            end
            if (rsp_data.last_char !== want.last_char) begin
               error_count++;
               $display("%0t: last_char expected %0b actual %0b",
                        $time, want.last_char, rsp_data.last_char);
            end
         end
      end
   end

   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = draw_wait(receiver_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < TableRows; i++) begin
         send_number(req_type'{directed_table[i].number, directed_table[i].sgn},
                     directed_table[i].text);
      end
      for (int i = 0; i < RandomNumbers; i++) begin
         send_number(random_number(), 160'd0);
      end
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Converted %0d numbers (%0d negative), %0d characters checked.",
               numbers_sent, negatives_sent, chars_checked);
      $display("Directed extremes and random values under random gaps and stalls.");
      if (error_count == 0) begin
         $display("** integer_to_decimal_ascii: PASSED **");
      end else begin
         $display("** integer_to_decimal_ascii: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- integer_to_decimal_ascii.f -----
hw/rtl/ida_pkg.sv
hw/rtl/ida_ctrl.sv
hw/rtl/ida_datapath.sv
hw/rtl/integer_to_decimal_ascii.sv
sim/tb.sv
